/* hw/rtl/rhtm_pkg.sv */
// ----------------------------------------------------------------------------
// rhtm_pkg
// Shared types and constants of the RGB hue threshold mask unit.
// ----------------------------------------------------------------------------
package rhtm_pkg;

  localparam int CH_W      = 8;   // input channel width
  localparam int HUE_W     = 10;  // signed hue and limit width
  localparam int QUOT_W    = 6;   // quotient bits, magnitude at most 60
  localparam int HUE_SCALE = 60;  // degrees per sector
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BELOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE = CFG_IDX_W'(1);

  localparam logic signed [HUE_W-1:0] BELOW_RST  = HUE_W'(60);
  localparam logic signed [HUE_W-1:0] ABOVE_RST  = HUE_W'(300);
  localparam logic signed [HUE_W-1:0] BASE_RED   = HUE_W'(0);
  localparam logic signed [HUE_W-1:0] BASE_GREEN = HUE_W'(120);
  localparam logic signed [HUE_W-1:0] BASE_BLUE  = HUE_W'(240);

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic    valid;
    logic    defined;
    logic    neg;
    sector_e sector;
  } ctl_t;

endpackage

/* hw/rtl/rgb_hue_threshold_mask_unit.sv */
// ----------------------------------------------------------------------------
// rgb_hue_threshold_mask_unit
// Per-pixel HSV hue and hue threshold mask, built as a front stage, a row
// of division cells and a result stage.
//
//   channel  direction  ports                            handshake
//   pixel    in         red_i green_i blue_i             start_i, busy_o
//   config   in         cfg_idx_i cfg_wdata_i            cfg_we_i
//   result   out        mask_o hue_o hue_defined_o       valid_o
//
// One word accepted per cycle; busy_o stays low. The pipeline holds one
// front stage, one cell per quotient bit and one result stage.
// Reset clears the valid bits of the pipeline and loads the limit defaults.
// Results are shown for one cycle with valid_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rgb_hue_threshold_mask_unit import rhtm_pkg::*; #(
  parameter int QUANT_BITS = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [CH_W-1:0]         red_i,
  input  logic [CH_W-1:0]         green_i,
  input  logic [CH_W-1:0]         blue_i,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [HUE_W-1:0]        cfg_wdata_i,
  output logic                    valid_o,
  output logic [CH_W-1:0]         mask_o,
  output logic signed [HUE_W-1:0] hue_o,
  output logic                    hue_defined_o
);

  localparam int NUM_W = QUANT_BITS + 6;

  ctl_t                  ctl_s  [QUOT_W+1];
  logic [NUM_W-1:0]      rem_s  [QUOT_W+1];
  logic [QUANT_BITS-1:0] span_s [QUOT_W+1];
  logic [QUOT_W-1:0]     quot_s [QUOT_W+1];

  logic signed [HUE_W-1:0] below_q, above_q;
  logic signed [HUE_W-1:0] base, offs, hue_d, hue_q;
  logic pass_d, valid_q, pass_q, defined_q;
  ctl_t ctl_last;

  assign busy_o = 1'b0;

  rhtm_front #(
    .Q_BITS (QUANT_BITS),
    .NUM_W  (NUM_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .ctl_o   (ctl_s[0]),
    .num_o   (rem_s[0]),
    .span_o  (span_s[0])
  );

  assign quot_s[0] = '0;

  for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
    rhtm_div_cell #(
      .Q_BITS (QUANT_BITS),
      .NUM_W  (NUM_W),
      .SHIFT  (QUOT_W - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_s[i]),
      .rem_i  (rem_s[i]),
      .span_i (span_s[i]),
      .quot_i (quot_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .span_o (span_s[i+1]),
      .quot_o (quot_s[i+1])
    );
  end

  assign ctl_last = ctl_s[QUOT_W];

  always_comb begin
    case (ctl_last.sector)
      SECT_RED:   base = BASE_RED;
      SECT_GREEN: base = BASE_GREEN;
      SECT_BLUE:  base = BASE_BLUE;
      default:    base = BASE_RED;
    endcase
    offs  = $signed(HUE_W'(quot_s[QUOT_W]));
    if (ctl_last.neg) offs = -offs;
    hue_d  = ctl_last.defined ? (base + offs) : '0;
    pass_d = ctl_last.defined && ((hue_d < below_q) || (hue_d > above_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      below_q <= BELOW_RST;
      above_q <= ABOVE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BELOW: below_q <= $signed(cfg_wdata_i);
        CFG_ABOVE: above_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q     <= hue_d;
    pass_q    <= pass_d;
    defined_q <= ctl_last.defined;
  end

  assign valid_o       = valid_q;
  assign mask_o        = pass_q ? '1 : '0;
  assign hue_o         = hue_q;
  assign hue_defined_o = defined_q;

endmodule

/* hw/rtl/rhtm_front.sv */
// ----------------------------------------------------------------------------
// rhtm_front
// Quantizes the pixel, finds max/min, picks the hue sector and builds the
// scaled dividend magnitude and the divisor.
// ----------------------------------------------------------------------------
module rhtm_front import rhtm_pkg::*; #(
  parameter int Q_BITS = 3,
  parameter int NUM_W  = Q_BITS + 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [CH_W-1:0]   red_i,
  input  logic [CH_W-1:0]   green_i,
  input  logic [CH_W-1:0]   blue_i,
  output ctl_t              ctl_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [Q_BITS-1:0] span_o
);

  logic [Q_BITS-1:0] r, g, b, hi, lo, mag;
  logic signed [Q_BITS:0] diff;
  ctl_t ctl_d, ctl_q;
  logic [NUM_W-1:0] num_d, num_q;
  logic [Q_BITS-1:0] span_d, span_q;

  assign r = red_i[CH_W-1 -: Q_BITS];
  assign g = green_i[CH_W-1 -: Q_BITS];
  assign b = blue_i[CH_W-1 -: Q_BITS];

  always_comb begin
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    span_d = hi - lo;

    ctl_d.valid   = valid_i;
    ctl_d.defined = (span_d != '0);
    if (hi == r) begin
      ctl_d.sector = SECT_RED;
      diff = $signed({1'b0, g}) - $signed({1'b0, b});
    end else if (hi == g) begin
      ctl_d.sector = SECT_GREEN;
      diff = $signed({1'b0, b}) - $signed({1'b0, r});
    end else begin
      ctl_d.sector = SECT_BLUE;
      diff = $signed({1'b0, r}) - $signed({1'b0, g});
    end
    ctl_d.neg = diff[Q_BITS];
    mag   = ctl_d.neg ? Q_BITS'(-diff) : diff[Q_BITS-1:0];
    num_d = NUM_W'(mag) * NUM_W'(HUE_SCALE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    span_q <= span_d;
  end

  assign ctl_o  = ctl_q;
  assign num_o  = num_q;
  assign span_o = span_q;

endmodule

/* hw/rtl/rhtm_div_cell.sv */
// ----------------------------------------------------------------------------
// rhtm_div_cell
// One restoring division step: settles quotient bit SHIFT and passes the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module rhtm_div_cell import rhtm_pkg::*; #(
  parameter int Q_BITS = 3,
  parameter int NUM_W  = Q_BITS + 6,
  parameter int SHIFT  = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctl_t              ctl_i,
  input  logic [NUM_W-1:0]  rem_i,
  input  logic [Q_BITS-1:0] span_i,
  input  logic [QUOT_W-1:0] quot_i,
  output ctl_t              ctl_o,
  output logic [NUM_W-1:0]  rem_o,
  output logic [Q_BITS-1:0] span_o,
  output logic [QUOT_W-1:0] quot_o
);

  logic [NUM_W-1:0] trial, rem_d, rem_q;
  logic [QUOT_W-1:0] quot_d, quot_q;
  logic [Q_BITS-1:0] span_q;
  logic ge;
  ctl_t ctl_q;

  always_comb begin
    trial  = NUM_W'(span_i) << SHIFT;
    ge     = (rem_i >= trial);
    rem_d  = ge ? (rem_i - trial) : rem_i;
    quot_d = quot_i;
    quot_d[SHIFT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    span_q <= span_i;
    quot_q <= quot_d;
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign span_o = span_q;
  assign quot_o = quot_q;

endmodule
